/* design/tlnf_pkg.sv */
// Shared types and constants for the text line numbering filter.
`default_nettype none
package tlnf_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

	// characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_MAX  = 8'd31;
	localparam logic [7:0] META_LO   = 8'd128;
	localparam logic [7:0] META_HI   = 8'd159;
	localparam logic [7:0] CTRL_BIAS = 8'h40;
	localparam logic [7:0] LOW7_MASK = 8'h7F;
	localparam logic [3:0] BCD_NINE  = 4'd9;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// how the back end expands one character
	typedef enum logic [5:0] {
		CLS_RAW  = 6'b000001,  // byte as is
		CLS_TAB  = 6'b000010,  // ^I
		CLS_END  = 6'b000100,  // $ then newline
		CLS_CTRL = 6'b001000,  // ^X
		CLS_DEL  = 6'b010000,  // ^?
		CLS_META = 6'b100000   // M-^X
	} char_class_t;

	typedef struct packed {
		logic        number;
		char_class_t cls;
		logic [7:0]  ch;
	} item_desc_t;

endpackage
`default_nettype wire

/* design/tlnf_if.sv */
// Valid/ready channel interfaces for input bytes and output bytes.
`default_nettype none
interface tlnf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_file;

	modport source (output valid, output data_byte, output new_file, input ready);
	modport sink (input valid, input data_byte, input new_file, output ready);
endinterface

interface tlnf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

/* design/text_line_numbering_filter_core.sv */
// Top level of the text line numbering filter: config registers, front, queue, back.
// An accepted word is written into the queue, then into the back end's output register.
// The back end emits one output word per cycle while result.ready holds; an item expands
//   into 1 word (typical) up to NUMBER_DIGITS + 5 words, squeezed lines into none.
// Input is taken every cycle while the two-entry queue between front and back has room.
// Reset (arst_n low, asynchronous): options clear, line start set, blank run 0, number 1.
`default_nettype none
module text_line_numbering_filter_core #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tlnf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic                             cfg_wdata,
	tlnf_in_if.sink                               text,
	tlnf_out_if.source                            result
);
	localparam int NW     = 4 * NUMBER_DIGITS;
	localparam int DW     = $bits(tlnf_pkg::item_desc_t);
	localparam int QWIDTH = DW + NW;

	tlnf_pkg::cfg_t       cfg_q;
	tlnf_pkg::item_desc_t f_desc, b_desc;
	logic [NW-1:0]        f_number, b_number;
	logic [QWIDTH-1:0]    q_rdata;
	logic                 q_full, q_push, q_pop, q_valid;

	// option registers; writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tlnf_pkg::REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_wdata;
				tlnf_pkg::REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_wdata;
				tlnf_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_wdata;
				tlnf_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_wdata;
				tlnf_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_wdata;
				tlnf_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: line tracking and classing, pushes one descriptor per kept byte
	tlnf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.text   (text),
		.full   (q_full),
		.push   (q_push),
		.desc   (f_desc),
		.number (f_number)
	);

	// descriptor queue: number snapshot travels with the item
	tlnf_fifo #(.WIDTH(QWIDTH), .DEPTH(2)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_number, f_desc}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	assign b_desc   = q_rdata[DW-1:0];
	assign b_number = q_rdata[QWIDTH-1:DW];

	// back: sequencer that walks digits, tab and character expansion
	tlnf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head        (b_desc),
		.head_number (b_number),
		.pop         (q_pop),
		.result      (result)
	);
endmodule
`default_nettype wire

/* design/tlnf_fifo.sv */
// Small register queue between front and back end.
`default_nettype none
module tlnf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  valid
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");
endmodule
`default_nettype wire

/* design/tlnf_front.sv */
// Front end: line state, squeeze and numbering decisions, character classing.
`default_nettype none
module tlnf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tlnf_pkg::cfg_t           cfg,
	tlnf_in_if.sink                       text,
	input  wire logic                     full,
	output logic                          push,
	output tlnf_pkg::item_desc_t          desc,
	output logic [4*NUMBER_DIGITS-1:0]    number
);
	localparam int NW = 4 * NUMBER_DIGITS;

	logic          at_line_start_q;
	logic [1:0]    blank_run_q;
	logic [NW-1:0] line_number_q;

	logic          accept, nl, tab, als, drop, do_number, all_nine, carry;
	logic [1:0]    br, br_next;
	logic [NW-1:0] num, num_bumped;
	logic [3:0]    d;
	logic [7:0]    c;

	assign text.ready = !full;
	assign accept     = text.valid && text.ready;
	assign c          = text.data_byte;
	assign nl         = (c == tlnf_pkg::CH_NL);
	assign tab        = (c == tlnf_pkg::CH_TAB);

	// a new file restarts everything before the byte is handled
	assign als = text.new_file ? 1'b1 : at_line_start_q;
	assign br  = text.new_file ? 2'd0 : blank_run_q;
	assign num = text.new_file ? NW'(1) : line_number_q;

	always_comb begin
		br_next = br;
		if (als) begin
			if (nl) begin
				br_next = (br == 2'd2) ? 2'd2 : br + 2'd1;
			end else begin
				br_next = 2'd0;
			end
		end
	end

	assign drop      = als && cfg.squeeze_blank && (br_next == 2'd2);
	assign do_number = als && !drop &&
		((cfg.number_nonblank && !nl) || (cfg.number_all && !cfg.number_nonblank));

	// BCD increment, holds at all nines
	always_comb begin
		all_nine   = 1'b1;
		carry      = 1'b1;
		num_bumped = num;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = num[4*i +: 4];
			if (d < tlnf_pkg::BCD_NINE) begin
				all_nine = 1'b0;
			end
			if (carry) begin
				if (d < tlnf_pkg::BCD_NINE) begin
					num_bumped[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end else begin
					num_bumped[4*i +: 4] = 4'd0;
				end
			end
		end
		if (all_nine) begin
			num_bumped = num;
		end
	end

	always_comb begin
		desc.number = do_number;
		desc.ch     = c;
		desc.cls    = tlnf_pkg::CLS_RAW;
		if (cfg.show_tabs && tab) begin
			desc.cls = tlnf_pkg::CLS_TAB;
		end else if (cfg.show_ends && nl) begin
			desc.cls = tlnf_pkg::CLS_END;
		end else if (cfg.show_nonprinting && !nl && !tab) begin
			if (c <= tlnf_pkg::CTRL_MAX) begin
				desc.cls = tlnf_pkg::CLS_CTRL;
			end else if (c == tlnf_pkg::CH_DEL) begin
				desc.cls = tlnf_pkg::CLS_DEL;
			end else if (c >= tlnf_pkg::META_LO && c <= tlnf_pkg::META_HI) begin
				desc.cls = tlnf_pkg::CLS_META;
			end
		end
	end

	assign push   = accept && !drop;
	assign number = num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			blank_run_q     <= 2'd0;
			line_number_q   <= NW'(1);
		end else if (accept) begin
			blank_run_q     <= br_next;
			line_number_q   <= do_number ? num_bumped : num;
			at_line_start_q <= drop ? 1'b1 : nl;
		end
	end

	a_drop_keeps_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drop |=> at_line_start_q && blank_run_q == 2'd2)
		else $error("squeezed line did not keep line start");
	a_number_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(&(~(line_number_q ^ {NUMBER_DIGITS{tlnf_pkg::BCD_NINE}}))) &&
		!(accept && text.new_file) |=> $stable(line_number_q))
		else $error("line number moved past all nines");
endmodule
`default_nettype wire

/* design/tlnf_back.sv */
// Back end: expands one queued item into output bytes, one word a cycle while result.ready holds.
`default_nettype none
module tlnf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire tlnf_pkg::item_desc_t       head,
	input  wire logic [4*NUMBER_DIGITS-1:0] head_number,
	output logic                            pop,
	tlnf_out_if.source                      result
);
	localparam int PW = $clog2(NUMBER_DIGITS + 6);

	logic [PW-1:0] pos_q, base, total, k_full;
	logic [1:0]    k;
	logic [2:0]    ch_cnt;
	logic [7:0]    ch_byte, digit_byte, cur_byte, low5;
	logic          load, cur_last;
	logic          nz_above [NUMBER_DIGITS+1];
	logic [3:0]    d;
	logic [7:0]    byte_q;
	logic          valid_q, last_q;

	assign base   = head.number ? PW'(NUMBER_DIGITS + 1) : '0;
	assign k_full = pos_q - base;
	assign k      = k_full[1:0];
	assign low5   = (head.ch & tlnf_pkg::LOW7_MASK) | tlnf_pkg::CTRL_BIAS;

	always_comb begin
		ch_cnt  = 3'd1;
		ch_byte = head.ch;
		case (head.cls)
			tlnf_pkg::CLS_RAW: begin
				ch_cnt  = 3'd1;
				ch_byte = head.ch;
			end
			tlnf_pkg::CLS_TAB: begin
				ch_cnt  = 3'd2;
				ch_byte = (k == 2'd0) ? tlnf_pkg::CH_CARET : tlnf_pkg::CH_I;
			end
			tlnf_pkg::CLS_END: begin
				ch_cnt  = 3'd2;
				ch_byte = (k == 2'd0) ? tlnf_pkg::CH_DOLLAR : tlnf_pkg::CH_NL;
			end
			tlnf_pkg::CLS_CTRL: begin
				ch_cnt  = 3'd2;
				ch_byte = (k == 2'd0) ? tlnf_pkg::CH_CARET : (head.ch | tlnf_pkg::CTRL_BIAS);
			end
			tlnf_pkg::CLS_DEL: begin
				ch_cnt  = 3'd2;
				ch_byte = (k == 2'd0) ? tlnf_pkg::CH_CARET : tlnf_pkg::CH_QMARK;
			end
			tlnf_pkg::CLS_META: begin
				ch_cnt = 3'd4;
				case (k)
					2'd0:    ch_byte = tlnf_pkg::CH_M;
					2'd1:    ch_byte = tlnf_pkg::CH_DASH;
					2'd2:    ch_byte = tlnf_pkg::CH_CARET;
					default: ch_byte = low5;
				endcase
			end
			default: begin
				ch_cnt  = 3'd1;
				ch_byte = head.ch;
			end
		endcase
	end

	assign total = base + PW'(ch_cnt);

	// leading zeros print as spaces, the lowest digit always prints
	always_comb begin
		nz_above[NUMBER_DIGITS] = 1'b0;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			nz_above[i] = nz_above[i+1] || (head_number[4*i +: 4] != 4'd0);
		end
	end

	always_comb begin
		d          = 4'd0;
		digit_byte = tlnf_pkg::CH_SPACE;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (pos_q == PW'(NUMBER_DIGITS - 1 - i)) begin
				d = head_number[4*i +: 4];
				if (d > tlnf_pkg::BCD_NINE) begin
					d = tlnf_pkg::BCD_NINE;
				end
				if (nz_above[i] || i == 0) begin
					digit_byte = tlnf_pkg::CH_ZERO + {4'd0, d};
				end else begin
					digit_byte = tlnf_pkg::CH_SPACE;
				end
			end
		end
	end

	always_comb begin
		if (head.number && pos_q < PW'(NUMBER_DIGITS)) begin
			cur_byte = digit_byte;
		end else if (head.number && pos_q == PW'(NUMBER_DIGITS)) begin
			cur_byte = tlnf_pkg::CH_TAB;
		end else begin
			cur_byte = ch_byte;
		end
	end

	assign cur_last = (pos_q == total - PW'(1));
	assign load     = head_valid && (!valid_q || result.ready);
	assign pop      = load && cur_last;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= cur_last ? '0 : pos_q + 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = valid_q;
	assign result.out_byte    = byte_q;
	assign result.last_of_run = last_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < total)
		else $error("expansion position past item end");
	a_idle_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> pos_q == '0)
		else $error("position not rewound with queue empty");
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid && result.last_of_run)
		else $error("item retired without last word");
endmodule
`default_nettype wire
